// ===== rtl/hsl_pkg.sv =====
// ============================================================================
// hsl_pkg: shared types and constants for the HSL to RGB converter
// Fixed-point formats, scaling constants and the item passed between parts.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

    // Fraction bits of the unit-range fixed-point format.
    localparam int FRAC_BITS = 20;

    // Unsigned width that holds 0..UNIT, and a signed working width.
    localparam int UW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 3;

    localparam longint UNIT = longint'(1) << FRAC_BITS;

    localparam logic [UW-1:0] UNIT_V       = UW'(UNIT);
    localparam logic [UW-1:0] HALF_V       = UW'(UNIT / 2);
    localparam logic [UW-1:0] THIRD_V      = UW'(UNIT / 3);
    localparam logic [UW-1:0] TWO_THIRDS_V = UW'((2 * UNIT) / 3);

    // Input limits.
    localparam logic [8:0] HUE_MAX = 9'd360;
    localparam logic [6:0] PCT_MAX = 7'd100;

    // Scaling x * UNIT / D is split as x * (UNIT / D) + x * (UNIT % D) / D.
    // The second term is small and is divided by a reciprocal multiply that
    // is exact over its whole range.
    localparam logic [UW-1:0] HUE_Q = UW'(UNIT / 360);
    localparam logic [8:0]    HUE_R = 9'(UNIT % 360);
    localparam logic [UW-1:0] PCT_Q = UW'(UNIT / 100);
    localparam logic [6:0]    PCT_R = 7'(UNIT % 100);

    localparam int HUE_RSH = 27;
    localparam logic [18:0] HUE_RECIP = 19'(((longint'(1) << HUE_RSH) + 359) / 360);
    localparam int PCT_RSH = 20;
    localparam logic [13:0] PCT_RECIP = 14'(((longint'(1) << PCT_RSH) + 99) / 100);

    // Product widths of the front part.
    localparam int HQ_W  = UW + 9;
    localparam int PQ_W  = UW + 7;
    localparam int HR_W  = 17;
    localparam int PR_W  = 14;
    localparam int HRP_W = HR_W + 19;
    localparam int PRP_W = PR_W + 14;

    // Widths of the back part.
    localparam int PROD_W = 2 * UW;
    localparam int T6_W   = UW + 3;
    localparam int VW     = UW + 1;
    localparam int CH_W   = VW + 8;

    // Channels.
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Depths of the parts.
    localparam int FRONT_DEPTH = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int BACK_DEPTH  = 6;
    localparam int CAPACITY    = FRONT_DEPTH + QUEUE_DEPTH + BACK_DEPTH;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_W      = $clog2(CAPACITY + 2);

    typedef logic [UW-1:0] t_unit;

    // One pixel scaled to the unit range.
    typedef struct packed {
        t_unit h;
        t_unit s;
        t_unit l;
    } t_hsl_item;

    // Piece of the hue ramp that a channel falls on.
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

`default_nettype wire

// ===== rtl/hsl_front.sv =====
// ============================================================================
// hsl_front: input stage of the HSL to RGB converter
// Limits the inputs to range and scales them to unit fixed point in two stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [8:0]         i_hue_degrees,
    input  wire logic [6:0]         i_saturation_percent,
    input  wire logic [6:0]         i_lightness_percent,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output hsl_pkg::t_hsl_item      o_item
);
    import hsl_pkg::*;

    logic [8:0]      hue_c;
    logic [6:0]      sat_c;
    logic [6:0]      lit_c;
    logic [HQ_W-1:0] hq_full;
    logic [PQ_W-1:0] sq_full;
    logic [PQ_W-1:0] lq_full;

    logic            r_s1_valid;
    t_unit           r_hq;
    t_unit           r_sq;
    t_unit           r_lq;
    logic [HR_W-1:0] r_hr;
    logic [PR_W-1:0] r_sr;
    logic [PR_W-1:0] r_lr;

    logic             r_s2_valid;
    t_hsl_item        r_item;
    t_hsl_item        n_item;
    logic [HRP_W-1:0] hr_prod;
    logic [PRP_W-1:0] sr_prod;
    logic [PRP_W-1:0] lr_prod;

    logic s1_ready;
    logic s2_ready;

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r_s2_valid;
    assign o_item   = r_item;

    // Out-of-range values are taken as the top of the range.
    always_comb begin
        hue_c   = (i_hue_degrees > HUE_MAX) ? HUE_MAX : i_hue_degrees;
        sat_c   = (i_saturation_percent > PCT_MAX) ? PCT_MAX : i_saturation_percent;
        lit_c   = (i_lightness_percent > PCT_MAX) ? PCT_MAX : i_lightness_percent;
        hq_full = HQ_W'(hue_c) * HQ_W'(HUE_Q);
        sq_full = PQ_W'(sat_c) * PQ_W'(PCT_Q);
        lq_full = PQ_W'(lit_c) * PQ_W'(PCT_Q);
    end

    always_comb begin
        hr_prod  = HRP_W'(r_hr) * HRP_W'(HUE_RECIP);
        sr_prod  = PRP_W'(r_sr) * PRP_W'(PCT_RECIP);
        lr_prod  = PRP_W'(r_lr) * PRP_W'(PCT_RECIP);
        n_item.h = r_hq + UW'(hr_prod >> HUE_RSH);
        n_item.s = r_sq + UW'(sr_prod >> PCT_RSH);
        n_item.l = r_lq + UW'(lr_prod >> PCT_RSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_hq <= hq_full[UW-1:0];
            r_sq <= sq_full[UW-1:0];
            r_lq <= lq_full[UW-1:0];
            r_hr <= HR_W'(hue_c) * HR_W'(HUE_R);
            r_sr <= PR_W'(sat_c) * PR_W'(PCT_R);
            r_lr <= PR_W'(lit_c) * PR_W'(PCT_R);
        end
        if (s2_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsl_queue.sv =====
// ============================================================================
// hsl_queue: short queue between the front and back parts
// Registered-flag FIFO that lets either side stall without stopping the other.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  hsl_pkg::t_hsl_item      i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output hsl_pkg::t_hsl_item      o_item
);
    import hsl_pkg::*;

    t_hsl_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsl_back.sv =====
// ============================================================================
// hsl_back: color computation of the HSL to RGB converter
// Forms the mixing levels, evaluates the hue ramp per channel, scales to 8 bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  hsl_pkg::t_hsl_item      i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_red_level,
    output logic [7:0]              o_green_level,
    output logic [7:0]              o_blue_level
);
    import hsl_pkg::*;

    logic [BACK_DEPTH-1:0] r_vld;
    logic [BACK_DEPTH:0]   stage_rdy;

    // Stage 1: product of lightness and saturation.
    logic [PROD_W-1:0] ls_full;
    t_hsl_item         r_b1_item;
    t_unit             r_b1_ls;

    // Stage 2: mixing levels and wrapped hue per channel.
    logic signed [SW-1:0] h_s, s_s, l_s, ls_s;
    logic signed [SW-1:0] hi_raw, lo_raw, hi_c, lo_c;
    logic signed [SW-1:0] t_raw [NUM_CH];
    logic signed [SW-1:0] t_wrap [NUM_CH];
    t_unit                r_b2_hi;
    t_unit                r_b2_lo;
    t_unit                r_b2_t [NUM_CH];

    // Stage 3: ramp piece and ramp factor per channel.
    logic [T6_W-1:0] t6 [NUM_CH];
    logic [T6_W-1:0] t2 [NUM_CH];
    logic [T6_W-1:0] t3 [NUM_CH];
    logic [T6_W-1:0] d6 [NUM_CH];
    t_unit           fall_dist [NUM_CH];
    t_seg            n_seg [NUM_CH];
    t_unit           n_fac [NUM_CH];
    t_unit           r_b3_hi;
    t_unit           r_b3_lo;
    t_unit           r_b3_span;
    t_seg            r_b3_seg [NUM_CH];
    t_unit           r_b3_fac [NUM_CH];

    // Stage 4: span times factor.
    logic [PROD_W-1:0] prod_full [NUM_CH];
    t_unit             r_b4_hi;
    t_unit             r_b4_lo;
    t_seg              r_b4_seg [NUM_CH];
    t_unit             r_b4_prod [NUM_CH];

    // Stage 5: ramp value.
    logic [VW-1:0] n_v [NUM_CH];
    logic [VW-1:0] r_b5_v [NUM_CH];

    // Stage 6: 8-bit levels, the output register.
    logic [CH_W-1:0] scaled [NUM_CH];
    logic [CH_W-1:0] lvl_full [NUM_CH];
    logic [7:0]      r_b6_lvl [NUM_CH];

    // A stage takes new data when it is empty or its successor moves on.
    always_comb begin
        stage_rdy[BACK_DEPTH] = i_ready;
        for (int k = BACK_DEPTH - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign o_ready = stage_rdy[0];
    assign o_valid = r_vld[BACK_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < BACK_DEPTH; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    assign ls_full = PROD_W'(i_item.l) * PROD_W'(i_item.s);

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_b1_item <= i_item;
            r_b1_ls   <= UW'(ls_full >> FRAC_BITS);
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        h_s    = $signed(SW'(r_b1_item.h));
        s_s    = $signed(SW'(r_b1_item.s));
        l_s    = $signed(SW'(r_b1_item.l));
        ls_s   = $signed(SW'(r_b1_ls));
        hi_raw = (r_b1_item.l < HALF_V) ? (l_s + ls_s) : (l_s + s_s - ls_s);
        lo_raw = l_s + l_s - hi_raw;
        lo_c   = (lo_raw < 0) ? '0 : lo_raw;
        hi_c   = (hi_raw < lo_c) ? lo_c : hi_raw;

        t_raw[CH_RED]   = h_s + $signed(SW'(THIRD_V));
        t_raw[CH_GREEN] = h_s;
        t_raw[CH_BLUE]  = h_s - $signed(SW'(THIRD_V));
        for (int c = 0; c < NUM_CH; c++) begin
            if (t_raw[c] < 0) begin
                t_wrap[c] = t_raw[c] + $signed(SW'(UNIT_V));
            end else if (t_raw[c] > $signed(SW'(UNIT_V))) begin
                t_wrap[c] = t_raw[c] - $signed(SW'(UNIT_V));
            end else begin
                t_wrap[c] = t_raw[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[1]) begin
            r_b2_hi <= UW'(hi_c);
            r_b2_lo <= UW'(lo_c);
            for (int c = 0; c < NUM_CH; c++) begin
                r_b2_t[c] <= UW'(t_wrap[c]);
            end
        end
    end

    // ---------------- stage 3 ----------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            t2[c]        = T6_W'(r_b2_t[c]) << 1;
            t6[c]        = (T6_W'(r_b2_t[c]) << 2) + t2[c];
            t3[c]        = T6_W'(r_b2_t[c]) + t2[c];
            fall_dist[c] = (r_b2_t[c] > TWO_THIRDS_V) ? '0 : (TWO_THIRDS_V - r_b2_t[c]);
            d6[c]        = (T6_W'(fall_dist[c]) << 2) + (T6_W'(fall_dist[c]) << 1);
            priority if (t6[c] < T6_W'(UNIT_V)) begin
                n_seg[c] = SEG_RISE;
                n_fac[c] = UW'(t6[c]);
            end else if (t2[c] < T6_W'(UNIT_V)) begin
                n_seg[c] = SEG_HIGH;
                n_fac[c] = '0;
            end else if (t3[c] < (T6_W'(UNIT_V) << 1)) begin
                n_seg[c] = SEG_FALL;
                n_fac[c] = UW'(d6[c]);
            end else begin
                n_seg[c] = SEG_LOW;
                n_fac[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[2]) begin
            r_b3_hi   <= r_b2_hi;
            r_b3_lo   <= r_b2_lo;
            r_b3_span <= r_b2_hi - r_b2_lo;
            for (int c = 0; c < NUM_CH; c++) begin
                r_b3_seg[c] <= n_seg[c];
                r_b3_fac[c] <= n_fac[c];
            end
        end
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod_full[c] = PROD_W'(r_b3_span) * PROD_W'(r_b3_fac[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[3]) begin
            r_b4_hi <= r_b3_hi;
            r_b4_lo <= r_b3_lo;
            for (int c = 0; c < NUM_CH; c++) begin
                r_b4_seg[c]  <= r_b3_seg[c];
                r_b4_prod[c] <= UW'(prod_full[c] >> FRAC_BITS);
            end
        end
    end

    // ---------------- stage 5 ----------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            unique case (r_b4_seg[c])
                SEG_RISE, SEG_FALL: n_v[c] = VW'(r_b4_lo) + VW'(r_b4_prod[c]);
                SEG_HIGH:           n_v[c] = VW'(r_b4_hi);
                SEG_LOW:            n_v[c] = VW'(r_b4_lo);
                default:            n_v[c] = VW'(r_b4_lo);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[4]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_b5_v[c] <= n_v[c];
            end
        end
    end

    // ---------------- stage 6 ----------------
    // Times 255 is a shift and a subtract; the level saturates at 255.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            scaled[c]   = (CH_W'(r_b5_v[c]) << 8) - CH_W'(r_b5_v[c]);
            lvl_full[c] = scaled[c] >> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[5]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_b6_lvl[c] <= (lvl_full[c] > CH_W'(255)) ? 8'hFF : lvl_full[c][7:0];
            end
        end
    end

    assign o_red_level   = r_b6_lvl[CH_RED];
    assign o_green_level = r_b6_lvl[CH_GREEN];
    assign o_blue_level  = r_b6_lvl[CH_BLUE];

endmodule

`default_nettype wire

// ===== rtl/hsl_to_rgb_converter.sv =====
// ============================================================================
// hsl_to_rgb_converter: HSL to 8-bit RGB color conversion
// Path: a transaction accepted at the input passes two front stages, the
//   two-entry queue and six back stages before its result is valid.
// Throughput: one transaction per cycle unless stalled (fully pipelined).
// Reset: synchronous and active low; it empties every stage and the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// The front part limits hue, saturation and lightness to range and scales
// them to unit fixed point with FRAC_BITS fraction bits. Scaling by 1/360 and
// 1/100 is done with a quotient constant and an exact reciprocal multiply on
// the small remainder term, so no divider is needed.
//
// A two-entry queue sits between front and back. Its ready is registered, so
// the input ready never depends combinationally on the output ready.
//
// The back part forms the two mixing levels, evaluates the piecewise hue ramp
// for red, green and blue at hue offsets of +1/3, 0 and -1/3, and scales each
// ramp value to an 8-bit level. Zero saturation needs no special path: both
// mixing levels then equal lightness and every channel gives the grey level.
module hsl_to_rgb_converter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [8:0] i_hue_degrees,
    input  wire logic [6:0] i_saturation_percent,
    input  wire logic [6:0] i_lightness_percent,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_red_level,
    output logic [7:0]      o_green_level,
    output logic [7:0]      o_blue_level
);
    import hsl_pkg::*;

    // Front to queue.
    logic      front_valid;
    logic      queue_ready;
    t_hsl_item front_item;

    // Queue to back.
    logic      queue_valid;
    logic      back_ready;
    t_hsl_item queue_item;

    hsl_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_hue_degrees        (i_hue_degrees),
        .i_saturation_percent (i_saturation_percent),
        .i_lightness_percent  (i_lightness_percent),
        .o_valid              (front_valid),
        .i_ready              (queue_ready),
        .o_item               (front_item)
    );

    hsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_item  (queue_item)
    );

    hsl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (queue_valid),
        .o_ready       (back_ready),
        .i_item        (queue_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level)
    );

endmodule

`default_nettype wire

// ===== rtl/hsl_checker.sv =====
// ============================================================================
// hsl_checker: port-level checks for the HSL to RGB converter
// Tracks transactions in flight and checks output behavior over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_red_level,
    input wire logic [7:0] o_green_level,
    input wire logic [7:0] o_blue_level
);
    import hsl_pkg::*;

    logic [PEND_W-1:0] r_pending;
    logic [PEND_W-1:0] n_pending;
    logic              in_fire;
    logic              out_fire;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_fire && !out_fire) begin
            n_pending = r_pending + 1'b1;
        end else if (out_fire && !in_fire) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A result only comes out of a transaction that went in.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pending != '0))
        else $error("result without an accepted transaction");

    // The block never holds more transactions than it has room for.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(CAPACITY))
        else $error("more transactions in flight than stages");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_level)
            && $stable(o_green_level) && $stable(o_blue_level)))
        else $error("stalled result changed");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (.*);

`default_nettype wire

// ===== verif/hsl_to_rgb_converter_tb.sv =====
// ============================================================================
// hsl_to_rgb_converter_tb: self-checking testbench for the HSL to RGB converter
// A stimulus table covers black, white, grey, the primaries and out-of-range
// inputs. Random pixels follow under random stalls on both handshakes. Every
// result is checked against typed levels or an in-bench fixed-point predictor.
// ============================================================================
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;

    import hsl_pkg::*;

    // Unstalled latency covers the two front stages, the queue and the back stages.
    localparam int PIPE_LATENCY = FRONT_DEPTH + 1 + BACK_DEPTH;
    localparam int RAND_ITEMS   = 1450;
    localparam int NUM_ROWS     = 25;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_PRINT    = 20;

    // One row of the directed table. Where typed is set, the expected levels
    // are given here. Otherwise the predictor supplies them.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lit;
        logic       typed;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_row;

    // One expected result, with the pixel that caused it for messages.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lit;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pixel_exp;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [8:0] i_hue_degrees;
    logic [6:0] i_saturation_percent;
    logic [6:0] i_lightness_percent;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_red_level;
    logic [7:0] o_green_level;
    logic [7:0] o_blue_level;

    // Table expectation that travels with the pixel on the input port.
    logic       row_typed;
    logic [7:0] row_r;
    logic [7:0] row_g;
    logic [7:0] row_b;

    t_row       dir_rows [0:NUM_ROWS-1];
    t_pixel_exp pixel_q [$];

    bit src_idle_en;
    bit sink_idle_en;
    bit hold_req;
    int stall_left;

    int errors;
    int pixels_sent;
    int results_checked;
    int typed_checked;
    int hold_count;
    int drain_count;

    hsl_to_rgb_converter dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_hue_degrees        (i_hue_degrees),
        .i_saturation_percent (i_saturation_percent),
        .i_lightness_percent  (i_lightness_percent),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_red_level          (o_red_level),
        .o_green_level        (o_green_level),
        .o_blue_level         (o_blue_level)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: unsigned fixed point with FRAC_BITS fraction bits.
    // ------------------------------------------------------------------------

    // Piecewise hue ramp between the low and high mixing levels at offset t.
    function automatic longint ramp_level(longint lo, longint hi, longint t);
        longint one;
        longint two_thirds;
        longint span;
        longint d;
        one        = longint'(1) << FRAC_BITS;
        two_thirds = (2 * one) / 3;
        span       = hi - lo;
        if (t < 0) t = t + one;
        if (t > one) t = t - one;
        if (t < 0) t = 0;
        if (6 * t < one) return lo + ((span * 6 * t) >> FRAC_BITS);
        if (2 * t < one) return hi;
        if (3 * t < 2 * one) begin
            d = two_thirds - t;
            if (d < 0) d = 0;
            return lo + ((span * 6 * d) >> FRAC_BITS);
        end
        return lo;
    endfunction

    // Unit-range value to an 8-bit level, truncated and limited to 0..255.
    function automatic logic [7:0] unit_to_level(longint v);
        longint lvl;
        if (v <= 0) return 8'd0;
        lvl = (v * 255) >> FRAC_BITS;
        return (lvl > 255) ? 8'd255 : lvl[7:0];
    endfunction

    function automatic t_pixel_exp rgb_from_hsl(logic [8:0] hue, logic [6:0] sat,
                                               logic [6:0] lit);
        t_pixel_exp px;
        longint     third;
        longint     half;
        longint     hv;
        longint     sv;
        longint     lv;
        longint     h;
        longint     s;
        longint     l;
        longint     ls;
        longint     hi;
        longint     lo;
        third = (longint'(1) << FRAC_BITS) / 3;
        half  = (longint'(1) << FRAC_BITS) >> 1;
        // Values above range are taken as the top of the range.
        hv = (hue > HUE_MAX) ? longint'(HUE_MAX) : longint'(hue);
        sv = (sat > PCT_MAX) ? longint'(PCT_MAX) : longint'(sat);
        lv = (lit > PCT_MAX) ? longint'(PCT_MAX) : longint'(lit);
        h  = (hv << FRAC_BITS) / longint'(HUE_MAX);
        s  = (sv << FRAC_BITS) / longint'(PCT_MAX);
        l  = (lv << FRAC_BITS) / longint'(PCT_MAX);
        px.hue = hue;
        px.sat = sat;
        px.lit = lit;
        if (sv == 0) begin
            // Zero saturation is grey at the lightness level.
            px.r = unit_to_level(l);
            px.g = px.r;
            px.b = px.r;
        end else begin
            ls = (l * s) >> FRAC_BITS;
            hi = (l < half) ? l + ls : l + s - ls;
            lo = 2 * l - hi;
            if (lo < 0) lo = 0;
            if (hi < lo) hi = lo;
            px.r = unit_to_level(ramp_level(lo, hi, h + third));
            px.g = unit_to_level(ramp_level(lo, hi, h));
            px.b = unit_to_level(ramp_level(lo, hi, h - third));
        end
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINT) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Presents one pixel at a falling edge and holds it until it is accepted.
    // Valid is left high so that a back-to-back pixel needs no second update.
    task automatic drive_pixel(input logic [8:0] hue, input logic [6:0] sat,
                               input logic [6:0] lit, input logic typed,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid              <= 1'b1;
        i_hue_degrees        <= hue;
        i_saturation_percent <= sat;
        i_lightness_percent  <= lit;
        row_typed            <= typed;
        row_r                <= r;
        row_g                <= g;
        row_b                <= b;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // Drops valid before the next rising edge, then waits for every result.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here on request.
    // ------------------------------------------------------------------------
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_count++;
                i_ready   <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (!sink_idle_en || $urandom_range(0, 99) < 70) begin
                i_ready <= 1'b1;
            end else begin
                i_ready   <= 1'b0;
                stall_left = idle_len() - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: the prediction is made when the input transaction is accepted.
    // Each output transaction is checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_pixel_exp want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = rgb_from_hsl(i_hue_degrees, i_saturation_percent,
                                    i_lightness_percent);
                if (row_typed) begin
                    want.r = row_r;
                    want.g = row_g;
                    want.b = row_b;
                    typed_checked++;
                end
                pixel_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with none expected",
                                              o_red_level, o_green_level, o_blue_level));
                end else begin
                    want = pixel_q.pop_front();
                    results_checked++;
                    if (o_red_level !== want.r)
                        report_mismatch($sformatf("hsl %0d/%0d/%0d red %0d, expected %0d",
                            want.hue, want.sat, want.lit, o_red_level, want.r));
                    if (o_green_level !== want.g)
                        report_mismatch($sformatf("hsl %0d/%0d/%0d green %0d, expected %0d",
                            want.hue, want.sat, want.lit, o_green_level, want.g));
                    if (o_blue_level !== want.b)
                        report_mismatch($sformatf("hsl %0d/%0d/%0d blue %0d, expected %0d",
                            want.hue, want.sat, want.lit, o_blue_level, want.b));
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pixel_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lit;
        int         kind;
        int         edge_hue;

        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_hue_degrees        = '0;
        i_saturation_percent = '0;
        i_lightness_percent  = '0;
        row_typed            = 1'b0;
        row_r                = '0;
        row_g                = '0;
        row_b                = '0;
        src_idle_en          = 1'b1;
        sink_idle_en         = 1'b1;
        hold_req             = 1'b0;
        errors               = 0;
        pixels_sent          = 0;
        results_checked      = 0;
        typed_checked        = 0;
        hold_count           = 0;
        drain_count          = 0;

        // hue, sat, lit, typed, red, green, blue
        dir_rows = '{
            '{9'd0,   7'd0,   7'd0,   1'b1, 8'd0,   8'd0,   8'd0},    // black
            '{9'd0,   7'd0,   7'd100, 1'b1, 8'd255, 8'd255, 8'd255},  // white, grey path
            '{9'd217, 7'd0,   7'd100, 1'b1, 8'd255, 8'd255, 8'd255},  // hue ignored
            '{9'd0,   7'd100, 7'd0,   1'b1, 8'd0,   8'd0,   8'd0},    // black, full sat
            '{9'd0,   7'd100, 7'd100, 1'b1, 8'd255, 8'd255, 8'd255},  // white, full sat
            '{9'd0,   7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},    // pure red
            '{9'd360, 7'd100, 7'd50,  1'b1, 8'd255, 8'd0,   8'd0},    // hue wraps at 360
            '{9'd120, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd240, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd60,  7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd180, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd300, 7'd100, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd511, 7'd127, 7'd127, 1'b0, 8'd0,   8'd0,   8'd0},    // all above range
            '{9'd361, 7'd101, 7'd101, 1'b0, 8'd0,   8'd0,   8'd0},    // just above range
            '{9'd0,   7'd127, 7'd50,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd200, 7'd50,  7'd127, 1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd123, 7'd0,   7'd37,  1'b0, 8'd0,   8'd0,   8'd0},    // grey
            '{9'd1,   7'd1,   7'd1,   1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd359, 7'd99,  7'd99,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd256, 7'd64,  7'd64,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd255, 7'd63,  7'd63,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd90,  7'd30,  7'd70,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd45,  7'd100, 7'd25,  1'b0, 8'd0,   8'd0,   8'd0},
            '{9'd330, 7'd75,  7'd49,  1'b0, 8'd0,   8'd0,   8'd0},    // lightness below half
            '{9'd30,  7'd40,  7'd51,  1'b0, 8'd0,   8'd0,   8'd0}     // lightness above half
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under random idling on both sides.
        for (int i = 0; i < NUM_ROWS; i++) begin
            drive_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].lit,
                        dir_rows[i].typed, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b);
        end
        wait_drained();
        drain_count++;

        // Random pixels. The phases vary who idles, with one long receiver
        // hold-off while the sender keeps pushing, and one full drain.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case (n)
                0: begin
                    src_idle_en  = 1'b0;
                    sink_idle_en = 1'b0;
                end
                150: begin
                    src_idle_en  = 1'b1;
                    sink_idle_en = 1'b1;
                end
                400: begin
                    src_idle_en = 1'b0;
                    hold_req    = 1'b1;
                end
                480: src_idle_en = 1'b1;
                700: begin
                    wait_drained();
                    drain_count++;
                end
                1000: sink_idle_en = 1'b0;
                1150: begin
                    sink_idle_en = 1'b1;
                    src_idle_en  = 1'b0;
                end
                1300: src_idle_en = 1'b1;
                default: ;
            endcase

            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                hue = 9'($urandom_range(0, 360));
                sat = 7'($urandom_range(0, 100));
                lit = 7'($urandom_range(0, 100));
            end else if (kind < 80) begin
                // Any bit pattern, out-of-range values included.
                hue = 9'($urandom);
                sat = 7'($urandom);
                lit = 7'($urandom);
            end else if (kind < 90) begin
                // Hue next to a sextant boundary, lightness next to one half.
                edge_hue = 60 * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
                if (edge_hue < 0) edge_hue = 0;
                if (edge_hue > 360) edge_hue = 360;
                hue = 9'(edge_hue);
                sat = 7'($urandom_range(0, 100));
                lit = 7'($urandom_range(48, 52));
            end else begin
                // Saturation at its extremes, zero included.
                hue = 9'($urandom_range(0, 511));
                sat = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(99, 127));
                lit = 7'($urandom_range(0, 127));
            end
            drive_pixel(hue, sat, lit, 1'b0, 8'd0, 8'd0, 8'd0);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);
        if (pixel_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pixel_q.size()));

        $display("Sent %0d pixels (%0d from the table, %0d with typed levels); %0d checked.",
                 pixels_sent, NUM_ROWS, typed_checked, results_checked);
        $display("Receiver hold-offs: %0d, full drains: %0d, mismatches: %0d.",
                 hold_count, drain_count, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hsl_pkg.sv
rtl/hsl_front.sv
rtl/hsl_queue.sv
rtl/hsl_back.sv
rtl/hsl_to_rgb_converter.sv
rtl/hsl_checker.sv
verif/hsl_to_rgb_converter_tb.sv
